// ----- sv/midi_cc_servo_slew_bank_top_macros.svh -----
// Assertion macros for the servo slew bank top level.
`ifndef MIDI_CC_SERVO_SLEW_BANK_TOP_MACROS_SVH
`define MIDI_CC_SERVO_SLEW_BANK_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCSSB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCSSB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mcssb_pkg.sv -----
// Types, constants and helper functions shared by the servo slew bank.
`default_nettype none

package mcssb_pkg;

    // request kinds
    typedef enum logic [1:0] {
        OP_CC   = 2'd0,
        OP_TICK = 2'd1,
        OP_SET  = 2'd2,
        OP_REC  = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ACTIVE = 3'd0,
        REG_COARSE = 3'd1,
        REG_FINE   = 3'd2,
        REG_SPEED  = 3'd3,
        REG_MIN    = 3'd4,
        REG_MAX    = 3'd5,
        REG_CENTER = 3'd6
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CC_MUL,
        S_CC_Q0,
        S_CC_FIX,
        S_CC_WR,
        S_TK_CHK,
        S_TK_STEP,
        S_TK_CLAMP,
        S_TK_DIV,
        S_TK_FIX,
        S_SET,
        S_REC,
        S_EMIT,
        S_DONE
    } t_eng_state;

    typedef struct packed {
        t_op         op;
        logic [6:0]  cc_number;
        logic [6:0]  cc_value;
        logic [1:0]  servo_index;
        logic [11:0] position_us;
        logic [7:0]  elapsed_ms;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  servo_id;
        logic [11:0] pulse_us;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [3:0]  active_mask;
        logic [31:0] coarse_cc_map;
        logic [31:0] fine_cc_map;
        logic [31:0] speed_cc_map;
        logic [47:0] min_pulse_map;
        logic [47:0] max_pulse_map;
        logic [47:0] center_pulse_map;
    } t_cfg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // queue depths, powers of two
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    localparam logic [7:0]  CC_NONE     = 8'hFF;
    localparam logic [13:0] FULL_SCALE  = 14'd16383;
    localparam logic [9:0]  SPEED_MIN   = 10'd500;
    localparam logic [14:0] SPEED_SPAN  = 15'd21500;
    localparam logic [6:0]  SPEED_DIV   = 7'd127;
    localparam logic [9:0]  MILLI       = 10'd1000;
    localparam logic [8:0]  HALF_MILLI  = 9'd500;
    // floor(2^32 / 1000)
    localparam logic [22:0] RECIP_MILLI = 23'd4294967;

    // CC number byte of a servo; servos past the map read as unassigned
    function automatic logic [7:0] cc_byte(logic [31:0] map, logic [2:0] idx);
        logic [7:0] b;
        b = CC_NONE;
        if (!idx[2]) begin
            case (idx[1:0])
                2'd0: b = map[7:0];
                2'd1: b = map[15:8];
                2'd2: b = map[23:16];
                default: b = map[31:24];
            endcase
        end
        return b;
    endfunction

    function automatic logic [11:0] pulse_field(logic [47:0] map, logic [2:0] idx);
        logic [11:0] p;
        p = '0;
        if (!idx[2]) begin
            case (idx[1:0])
                2'd0: p = map[11:0];
                2'd1: p = map[23:12];
                2'd2: p = map[35:24];
                default: p = map[47:36];
            endcase
        end
        return p;
    endfunction

    function automatic logic servo_active(logic [3:0] mask, logic [2:0] idx);
        return !idx[2] && mask[idx[1:0]];
    endfunction

endpackage

`default_nettype wire

// ----- sv/mcssb_front.sv -----
// Front end: decodes incoming requests and queues them for the engine.
`default_nettype none

module mcssb_front
    import mcssb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [6:0]  i_cc_number,
    input  logic [6:0]  i_cc_value,
    input  logic [1:0]  i_servo_index,
    input  logic [11:0] i_position_us,
    input  logic [7:0]  i_elapsed_ms,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_pop
);
    localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

    t_cmd            r_mem [CMD_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;
    logic [PW:0]     n_cnt;
    t_op             op;
    logic            wr;
    logic            rd;

    always_comb begin
        unique case (i_func)
            2'd0:    op = OP_CC;
            2'd1:    op = OP_TICK;
            2'd2:    op = OP_SET;
            default: op = OP_REC;
        endcase
    end

    assign o_full      = (r_cnt == (PW+1)'(CMD_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rd];
    assign wr          = i_push && !o_full;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_comb begin
        case ({wr, rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= '{op: op, cc_number: i_cc_number, cc_value: i_cc_value,
                             servo_index: i_servo_index, position_us: i_position_us,
                             elapsed_ms: i_elapsed_ms};
        end
    end

endmodule

`default_nettype wire

// ----- sv/mcssb_engine.sv -----
// Back end: updates per-servo state; CC/tick walk all servos, set/rec one.
`default_nettype none

module mcssb_engine
    import mcssb_pkg::*;
#(
    parameter int SERVOS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res
);
    localparam int IW = (SERVOS > 1) ? $clog2(SERVOS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SERVOS - 1);

    t_eng_state r_state;
    t_eng_state n_state;
    t_eng_state next_servo;

    // per-servo state
    logic [21:0] r_pos    [SERVOS];
    logic [11:0] r_tgt    [SERVOS];
    logic [14:0] r_spd    [SERVOS];
    logic [6:0]  r_coarse [SERVOS];

    t_cmd               r_cmd;
    logic [IW-1:0]      r_idx;
    logic               r_idx_ok;
    logic               r_mc;
    logic               r_mf;
    logic               r_ms;
    logic signed [27:0] r_prod;
    logic [21:0]        r_spx;
    logic [25:0]        r_abs;
    logic               r_neg;
    logic [12:0]        r_q0;
    logic [15:0]        r_sq0;
    logic [11:0]        r_q;
    logic [14:0]        r_sq;
    logic [22:0]        r_lim;
    logic signed [23:0] r_diff;
    logic signed [25:0] r_sum;
    logic [22:0]        r_y;
    t_res               r_new;
    t_res               r_pend;
    logic               r_pend_v;

    logic [2:0]  sel;
    logic [7:0]  coarse_b;
    logic [7:0]  fine_b;
    logic [7:0]  speed_b;
    logic [11:0] min_p;
    logic [11:0] max_p;
    logic [11:0] ctr_p;
    logic        act;
    logic        at_last;
    logic        stall;
    logic        idx_inc;
    logic [7:0]  num8;
    logic        match_c;
    logic        match_f;
    logic        match_s;

    // control change datapath
    logic [13:0]        full14;
    logic signed [12:0] span;
    logic signed [27:0] prod;
    logic [21:0]        spx;
    logic [27:0]        abs_w;
    logic [26:0]        q0_sum;
    logic [22:0]        sp_sum;
    logic [27:0]        map_back;
    logic [27:0]        map_rem;
    logic [12:0]        map_q;
    logic [22:0]        spd_back;
    logic [22:0]        spd_rem;
    logic [15:0]        spd_q;
    logic signed [13:0] tgt_sum;
    logic [14:0]        spd_new;

    // tick datapath
    logic [21:0]        pos_cur;
    logic [21:0]        tgt_milli;
    logic               pos_eq;
    logic [22:0]        lim_w;
    logic signed [23:0] diff_w;
    logic signed [24:0] lim_s;
    logic signed [24:0] diff25;
    logic signed [24:0] cdiff;
    logic signed [25:0] sum_w;
    logic [21:0]        lo_milli;
    logic [21:0]        hi_milli;
    logic [21:0]        npos;
    logic [22:0]        y_w;
    logic [45:0]        recip_prod;
    logic [22:0]        ms_back;
    logic [22:0]        ms_rem;
    logic [12:0]        tq;

    // set target / recenter
    logic [11:0] set_tgt;
    logic [21:0] ctr_milli;

    assign sel      = 3'(r_idx);
    assign coarse_b = cc_byte(i_cfg.coarse_cc_map, sel);
    assign fine_b   = cc_byte(i_cfg.fine_cc_map, sel);
    assign speed_b  = cc_byte(i_cfg.speed_cc_map, sel);
    assign min_p    = pulse_field(i_cfg.min_pulse_map, sel);
    assign max_p    = pulse_field(i_cfg.max_pulse_map, sel);
    assign ctr_p    = pulse_field(i_cfg.center_pulse_map, sel);
    assign act      = servo_active(i_cfg.active_mask, sel);
    assign at_last  = (r_idx == LAST_IDX);
    assign stall    = r_pend_v && i_res_full;

    assign num8    = {1'b0, r_cmd.cc_number};
    assign match_c = (num8 == coarse_b);
    assign match_f = !match_c && (num8 == fine_b);
    assign match_s = (num8 == speed_b);

    // coarse alone repeats its value into the low bits
    always_comb begin
        if (match_c) begin
            full14 = {r_cmd.cc_value, (fine_b != CC_NONE) ? 7'd0 : r_cmd.cc_value};
        end else begin
            full14 = {r_coarse[r_idx], r_cmd.cc_value};
        end
    end

    assign span = signed'({1'b0, max_p}) - signed'({1'b0, min_p});
    assign prod = signed'({1'b0, full14}) * span;
    assign spx  = 22'(r_cmd.cc_value) * 22'(SPEED_SPAN);

    // divide by 2^14-1 and 2^7-1: series estimate, then one correction step
    assign abs_w  = r_prod[27] ? 28'(-r_prod) : 28'(r_prod);
    assign q0_sum = 27'(abs_w[25:0]) + 27'(abs_w[25:14]);
    assign sp_sum = 23'(r_spx) + 23'(r_spx[21:7]) + 23'(r_spx[21:14]) + 23'(r_spx[21:21]);

    assign map_back = {1'b0, r_q0, 14'd0} - 28'(r_q0);
    assign map_rem  = 28'(r_abs) - map_back;
    assign map_q    = r_q0 + 13'(map_rem >= 28'(FULL_SCALE));
    assign spd_back = {r_sq0, 7'd0} - 23'(r_sq0);
    assign spd_rem  = 23'(r_spx) - spd_back;
    assign spd_q    = r_sq0 + 16'(spd_rem >= 23'(SPEED_DIV));

    // quotient truncates toward zero, so the sign goes on after dividing
    assign tgt_sum = signed'({2'b00, min_p})
                   + (r_neg ? -signed'({2'b00, r_q}) : signed'({2'b00, r_q}));
    assign spd_new = 15'(SPEED_MIN) + r_sq;

    assign pos_cur   = r_pos[r_idx];
    assign tgt_milli = 22'(r_tgt[r_idx]) * 22'(MILLI);
    assign pos_eq    = (pos_cur == tgt_milli);
    assign lim_w     = 23'(r_spd[r_idx]) * 23'(r_cmd.elapsed_ms);
    assign diff_w    = signed'({2'b00, tgt_milli}) - signed'({2'b00, pos_cur});

    assign lim_s  = signed'({2'b00, r_lim});
    assign diff25 = 25'(r_diff);
    always_comb begin
        if (diff25 < -lim_s) begin
            cdiff = -lim_s;
        end else if (diff25 > lim_s) begin
            cdiff = lim_s;
        end else begin
            cdiff = diff25;
        end
    end
    assign sum_w = 26'(cdiff) + signed'({4'b0000, pos_cur});

    // min is tested first; when min > max, only a sum below min gives min
    assign lo_milli = 22'(min_p) * 22'(MILLI);
    assign hi_milli = 22'(max_p) * 22'(MILLI);
    always_comb begin
        if (r_sum < signed'({4'b0000, lo_milli})) begin
            npos = lo_milli;
        end else if (r_sum > signed'({4'b0000, hi_milli})) begin
            npos = hi_milli;
        end else begin
            npos = r_sum[21:0];
        end
    end
    assign y_w = 23'(npos) + 23'(HALF_MILLI);

    // round to microseconds: reciprocal estimate, then one correction step
    assign recip_prod = 46'(r_y) * 46'(RECIP_MILLI);
    assign ms_back    = 23'(r_q0) * 23'(MILLI);
    assign ms_rem     = r_y - ms_back;
    assign tq         = r_q0 + 13'(ms_rem >= 23'(MILLI));

    always_comb begin
        if (r_cmd.position_us < min_p) begin
            set_tgt = min_p;
        end else if (r_cmd.position_us > max_p) begin
            set_tgt = max_p;
        end else begin
            set_tgt = r_cmd.position_us;
        end
    end
    assign ctr_milli = 22'(ctr_p) * 22'(MILLI);

    assign next_servo = at_last ? S_DONE : ((r_cmd.op == OP_TICK) ? S_TK_CHK : S_CC_MUL);
    assign idx_inc    = (r_state != S_IDLE) && ((n_state == S_TK_CHK) || (n_state == S_CC_MUL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = r_pend;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_CC:   n_state = S_CC_MUL;
                        OP_TICK: n_state = S_TK_CHK;
                        OP_SET:  n_state = S_SET;
                        default: n_state = S_REC;
                    endcase
                end
            end
            S_CC_MUL: begin
                n_state = (match_c || match_f || match_s) ? S_CC_Q0 : next_servo;
            end
            S_CC_Q0:    n_state = S_CC_FIX;
            S_CC_FIX:   n_state = S_CC_WR;
            S_CC_WR:    n_state = next_servo;
            S_TK_CHK: begin
                n_state = (!act || pos_eq) ? next_servo : S_TK_STEP;
            end
            S_TK_STEP:  n_state = S_TK_CLAMP;
            S_TK_CLAMP: n_state = S_TK_DIV;
            S_TK_DIV:   n_state = S_TK_FIX;
            S_TK_FIX:   n_state = S_EMIT;
            S_SET:      n_state = S_DONE;
            S_REC:      n_state = (r_idx_ok && act) ? S_EMIT : S_DONE;
            S_EMIT: begin
                if (!stall) begin
                    o_res_push = r_pend_v;
                    n_state    = (r_cmd.op == OP_REC) ? S_DONE : next_servo;
                end
            end
            S_DONE: begin
                if (!stall) begin
                    o_res_push = r_pend_v;
                    o_res.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // servo state and the pending-result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SERVOS; k++) begin
                r_pos[k]    <= '0;
                r_tgt[k]    <= '0;
                r_spd[k]    <= '0;
                r_coarse[k] <= '0;
            end
            r_pend_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_CC_MUL: begin
                    if (match_c) begin
                        r_coarse[r_idx] <= r_cmd.cc_value;
                    end
                end
                S_CC_WR: begin
                    if (r_mc || r_mf) begin
                        r_tgt[r_idx] <= tgt_sum[11:0];
                    end
                    if (r_ms) begin
                        r_spd[r_idx] <= spd_new;
                    end
                end
                S_TK_CLAMP: r_pos[r_idx] <= npos;
                S_SET: begin
                    if (r_idx_ok && act) begin
                        r_tgt[r_idx] <= set_tgt;
                    end
                end
                S_REC: begin
                    if (r_idx_ok) begin
                        r_pos[r_idx] <= ctr_milli;
                    end
                end
                S_EMIT: begin
                    if (!stall) begin
                        r_pend_v <= 1'b1;
                    end
                end
                S_DONE: begin
                    if (!stall) begin
                        r_pend_v <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd    <= i_cmd;
            r_idx    <= ((i_cmd.op == OP_SET) || (i_cmd.op == OP_REC))
                        ? IW'(i_cmd.servo_index) : '0;
            r_idx_ok <= (int'(i_cmd.servo_index) < SERVOS);
        end else if (idx_inc) begin
            r_idx <= IW'(r_idx + 1'b1);
        end
        unique case (r_state)
            S_CC_MUL: begin
                r_mc   <= match_c;
                r_mf   <= match_f;
                r_ms   <= match_s;
                r_prod <= prod;
                r_spx  <= spx;
            end
            S_CC_Q0: begin
                r_abs <= abs_w[25:0];
                r_neg <= r_prod[27];
                r_q0  <= q0_sum[26:14];
                r_sq0 <= sp_sum[22:7];
            end
            S_CC_FIX: begin
                r_q  <= map_q[11:0];
                r_sq <= spd_q[14:0];
            end
            S_TK_CHK: begin
                r_lim  <= lim_w;
                r_diff <= diff_w;
            end
            S_TK_STEP:  r_sum <= sum_w;
            S_TK_CLAMP: r_y <= y_w;
            S_TK_DIV:   r_q0 <= recip_prod[44:32];
            S_TK_FIX: begin
                r_new <= '{servo_id: 2'(r_idx), pulse_us: tq[11:0], last: 1'b0};
            end
            S_REC: begin
                r_new <= '{servo_id: 2'(r_idx), pulse_us: ctr_p, last: 1'b0};
            end
            S_EMIT: begin
                if (!stall) begin
                    r_pend <= r_new;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/mcssb_res_q.sv -----
// Result queue between the engine and the output port.
`default_nettype none

module mcssb_res_q
    import mcssb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    output logic o_empty,
    output t_res o_res,
    input  logic i_pop
);
    localparam int PW = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;

    t_res          r_mem [RES_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;
    logic [PW:0]   n_cnt;
    logic          wr;
    logic          rd;

    assign o_full  = (r_cnt == (PW+1)'(RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_comb begin
        case ({wr, rd})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (wr) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- sv/midi_cc_servo_slew_bank_top.sv -----
// Top level of the MIDI CC driven servo slew bank.
//
// Requests enter through a queue port: one is taken at a clock edge with push
// high and full low. func selects control change, tick, set target or
// recenter. Results leave through a second queue port: while empty is low the
// oldest result sits on o_servo_id/o_pulse_us/o_last and pop takes it. o_last
// marks the final result of a request; control changes and set target give
// none, recenter gives one for an attached servo, a tick one per moving servo.
// Configuration goes through i_cfg_we/i_cfg_index/i_cfg_data, one register per
// edge; index 7 is ignored. The user must write it only while no request is
// in flight; the block itself does not enforce this. The engine walks the
// servos one at a time; a control change does more work on a servo whose CC
// number matches, a tick on a servo that moves, while set target and recenter
// touch only the servo named. A two-entry request queue keeps taking requests
// while the engine works. A result is held back until the next one or the end
// of the request, so o_last is known; the final one is pushed, marked last, as
// the engine ends the request. A stalled receiver fills the result queue and
// then holds the engine. Synchronous reset empties both queues, zeroes every
// servo and loads the register defaults (all CC numbers unassigned).
`default_nettype none

`include "midi_cc_servo_slew_bank_top_macros.svh"

module midi_cc_servo_slew_bank_top
    import mcssb_pkg::*;
#(
    parameter int SERVOS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_func,
    input  logic [6:0]            i_cc_number,
    input  logic [6:0]            i_cc_value,
    input  logic [1:0]            i_servo_index,
    input  logic [11:0]           i_position_us,
    input  logic [7:0]            i_elapsed_ms,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_servo_id,
    output logic [11:0]           o_pulse_us,
    output logic                  o_last
);
    t_cfg r_cfg;
    t_cfg n_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;
    logic res_push;
    logic res_full;
    t_res eng_res;
    t_res out_res;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ACTIVE: n_cfg.active_mask      = i_cfg_data[3:0];
                REG_COARSE: n_cfg.coarse_cc_map    = i_cfg_data[31:0];
                REG_FINE:   n_cfg.fine_cc_map      = i_cfg_data[31:0];
                REG_SPEED:  n_cfg.speed_cc_map     = i_cfg_data[31:0];
                REG_MIN:    n_cfg.min_pulse_map    = i_cfg_data;
                REG_MAX:    n_cfg.max_pulse_map    = i_cfg_data;
                REG_CENTER: n_cfg.center_pulse_map = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{active_mask: '0, coarse_cc_map: '1, fine_cc_map: '1,
                       speed_cc_map: '1, min_pulse_map: '0, max_pulse_map: '0,
                       center_pulse_map: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // request decode and queue
    mcssb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_func        (i_func),
        .i_cc_number   (i_cc_number),
        .i_cc_value    (i_cc_value),
        .i_servo_index (i_servo_index),
        .i_position_us (i_position_us),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // per-servo sequencer
    mcssb_engine #(
        .SERVOS (SERVOS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (eng_res)
    );

    // result queue toward the receiver
    mcssb_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (eng_res),
        .o_full  (res_full),
        .o_empty (empty),
        .o_res   (out_res),
        .i_pop   (pop)
    );

    assign o_servo_id = out_res.servo_id;
    assign o_pulse_us = out_res.pulse_us;
    assign o_last     = out_res.last;

    `MCSSB_ASSERT_SAME(a_res_no_overflow, res_push, !res_full, "result pushed into a full queue")
    `MCSSB_ASSERT_SAME(a_cmd_pop_valid, cmd_pop, cmd_valid, "request taken from an empty queue")
    `MCSSB_ASSERT_NEXT(a_empty_holds, empty && !res_push, empty, "result appeared without a push")
    `MCSSB_ASSERT_NEXT(a_full_holds, full && !cmd_pop, full, "request queue drained without a pop")

endmodule

`default_nettype wire
